// ----- src/cscm_pkg.sv -----
package cscm_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_BRIGHT = 1'd1;

  localparam logic [15:0] HALF_PERIOD_RST  = 16'd500;
  localparam logic [3:0]  START_BRIGHT_RST = 4'd0;
  localparam logic [5:0]  MINUTE_MAX       = 6'd59;
  localparam logic [4:0]  HOUR_MAX         = 5'd23;
  localparam logic [3:0]  BRIGHT_MAX       = 4'd15;

  typedef enum logic [2:0] {
    MODE_MAIN   = 3'd0,
    MODE_TIME   = 3'd1,
    MODE_ALARM  = 3'd2,
    MODE_BRIGHT = 3'd3,
    MODE_RING   = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    KIND_TICK  = 3'd0,
    KIND_RIGHT = 3'd1,
    KIND_LEFT  = 3'd2,
    KIND_PRESS = 3'd3,
    KIND_RTC   = 3'd4,
    KIND_PIN   = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    CMD_NONE       = 3'd0,
    CMD_WR_TIME    = 3'd1,
    CMD_WR_ALARM   = 3'd2,
    CMD_SAVE_BRT   = 3'd3,
    CMD_CLR_ALARM  = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0] kind;
    logic [4:0] rtc_hour;
    logic [5:0] rtc_minute;
    logic       pin_level;
    logic       alarm_flag;
  } in_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] menu_position;
    logic       edit_hours;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [3:0] level;
    logic       digits_visible;
    logic       flash_on;
    logic [2:0] command;
  } out_t;

  typedef struct packed {
    mode_e       mode;
    logic [1:0]  position;
    logic        field;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [3:0]  bright;
    logic        visible;
    logic        flash;
    logic [15:0] elapsed;
    logic        prev_pin;
  } state_t;

endpackage

// ----- src/cscm_stage.sv -----
module cscm_stage #(
  parameter type T = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  T     data_i,
  output logic valid_o,
  input  logic ready_i,
  output T     data_o
);

  logic valid_q;
  T     data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

endmodule

// ----- src/cscm_next.sv -----
module cscm_next (
  input  cscm_pkg::state_t st_i,
  input  cscm_pkg::in_t    item_i,
  input  logic [15:0]      half_period_i,
  output cscm_pkg::state_t st_o,
  output cscm_pkg::out_t   res_o
);

  logic        set_mode;
  logic [6:0]  m_inc;
  logic        m_over;
  logic [5:0]  h_inc;
  logic [4:0]  inc_hour;
  logic [5:0]  inc_min;
  logic        min_under;
  logic        hour_dec;
  logic        hour_under;
  logic [4:0]  dec_hour;
  logic [5:0]  dec_min;
  logic [15:0] tick_cnt;
  cscm_pkg::cmd_e   cmd;
  cscm_pkg::state_t st_d;

  assign set_mode = (st_i.mode == cscm_pkg::MODE_TIME) || (st_i.mode == cscm_pkg::MODE_ALARM);

  // Right turn: bump the edited field, carry a minute overflow into the hour.
  assign m_inc    = {1'b0, st_i.minute} + {6'd0, !st_i.field};
  assign m_over   = m_inc > {1'b0, cscm_pkg::MINUTE_MAX};
  assign h_inc    = {1'b0, st_i.hour} + {5'd0, st_i.field} + {5'd0, m_over};
  assign inc_hour = (h_inc > {1'b0, cscm_pkg::HOUR_MAX}) ? 5'd0 : h_inc[4:0];
  assign inc_min  = m_over ? 6'd0 : m_inc[5:0];

  // Left turn: an hour underflow lands on 23:59.
  assign min_under  = !st_i.field && (st_i.minute == 6'd0);
  assign hour_dec   = st_i.field || min_under;
  assign hour_under = hour_dec && (st_i.hour == 5'd0);
  assign dec_hour   = hour_under ? cscm_pkg::HOUR_MAX : (st_i.hour - {4'd0, hour_dec});
  assign dec_min    = (hour_under || min_under) ? cscm_pkg::MINUTE_MAX :
                      (st_i.field ? st_i.minute : st_i.minute - 6'd1);

  assign tick_cnt = (st_i.elapsed != 16'hFFFF) ? st_i.elapsed + 16'd1 : st_i.elapsed;

  always_comb begin
    st_d = st_i;
    cmd  = cscm_pkg::CMD_NONE;
    case (cscm_pkg::kind_e'(item_i.kind))
      cscm_pkg::KIND_TICK: begin
        st_d.elapsed = tick_cnt;
        if (tick_cnt > half_period_i) begin
          if (set_mode) begin
            st_d.visible = !st_i.visible;
            st_d.elapsed = 16'd0;
          end else if (st_i.mode == cscm_pkg::MODE_RING) begin
            st_d.flash   = !st_i.flash;
            st_d.elapsed = 16'd0;
          end
        end
      end
      cscm_pkg::KIND_RIGHT, cscm_pkg::KIND_LEFT: begin
        if (st_i.mode == cscm_pkg::MODE_MAIN) begin
          st_d.position = st_i.position +
                          ((item_i.kind == cscm_pkg::KIND_RIGHT) ? 2'd1 : 2'd3);
        end else if (set_mode) begin
          st_d.elapsed = 16'd0;
          st_d.visible = 1'b1;
          if (item_i.kind == cscm_pkg::KIND_RIGHT) begin
            st_d.hour   = inc_hour;
            st_d.minute = inc_min;
          end else begin
            st_d.hour   = dec_hour;
            st_d.minute = dec_min;
          end
        end else if (st_i.mode == cscm_pkg::MODE_BRIGHT) begin
          if (item_i.kind == cscm_pkg::KIND_RIGHT) begin
            if (st_i.bright != cscm_pkg::BRIGHT_MAX) st_d.bright = st_i.bright + 4'd1;
          end else begin
            if (st_i.bright != 4'd0) st_d.bright = st_i.bright - 4'd1;
          end
        end
      end
      cscm_pkg::KIND_PRESS: begin
        unique case (st_i.mode)
          cscm_pkg::MODE_RING: begin
            st_d.mode     = cscm_pkg::MODE_MAIN;
            st_d.position = 2'd0;
          end
          cscm_pkg::MODE_MAIN: begin
            st_d.mode = cscm_pkg::mode_e'({1'b0, st_i.position});
          end
          cscm_pkg::MODE_TIME, cscm_pkg::MODE_ALARM: begin
            if (!st_i.field) begin
              st_d.field = 1'b1;
            end else begin
              cmd = (st_i.mode == cscm_pkg::MODE_TIME) ? cscm_pkg::CMD_WR_TIME :
                                                          cscm_pkg::CMD_WR_ALARM;
              st_d.field    = 1'b0;
              st_d.mode     = cscm_pkg::MODE_MAIN;
              st_d.position = 2'd0;
            end
          end
          cscm_pkg::MODE_BRIGHT: begin
            cmd           = cscm_pkg::CMD_SAVE_BRT;
            st_d.field    = 1'b0;
            st_d.mode     = cscm_pkg::MODE_MAIN;
            st_d.position = 2'd0;
          end
          default: ;
        endcase
      end
      cscm_pkg::KIND_RTC: begin
        if ((st_i.mode == cscm_pkg::MODE_MAIN) && (st_i.position == 2'd0)) begin
          st_d.hour   = item_i.rtc_hour;
          st_d.minute = item_i.rtc_minute;
        end
      end
      cscm_pkg::KIND_PIN: begin
        if (!item_i.pin_level && st_i.prev_pin && item_i.alarm_flag) begin
          st_d.mode = cscm_pkg::MODE_RING;
          cmd       = cscm_pkg::CMD_CLR_ALARM;
        end
        st_d.prev_pin = item_i.pin_level;
      end
      default: ;
    endcase
  end

  assign st_o = st_d;

  always_comb begin
    res_o.mode           = st_d.mode;
    res_o.menu_position  = st_d.position;
    res_o.edit_hours     = st_d.field;
    res_o.hours          = st_d.hour;
    res_o.minutes        = st_d.minute;
    res_o.level          = st_d.bright;
    res_o.digits_visible = st_d.visible;
    res_o.flash_on       = (st_d.mode == cscm_pkg::MODE_RING) ? st_d.flash : 1'b0;
    res_o.command        = cmd;
  end

endmodule

// ----- src/clock_setting_menu_controller_top.sv -----
// Menu controller for an alarm clock. Each input beat is one event: a
// millisecond tick, an encoder turn right or left, a press, a time read from
// the real-time clock, or a change of the clock's interrupt pin. Every input
// beat yields exactly one output beat with the menu state after the event
// (mode, menu position, edited field, hours, minutes, brightness, blink and
// flash state) and a command for the clock chip or for storage.
// Both channels use valid/ready. An input beat lands in the input register;
// once the output register can take it, the state update and the result
// are formed in one short combinational pass and captured in the output
// register. While the receiver keeps taking results, one beat is taken
// every cycle.
// When the receiver stalls, the output register holds its beat and the
// input register can still take one more; after that in_ready_o drops until
// the receiver takes the result.
// Reset empties both registers, puts the menu in main mode at position 0
// with 00:00 shown, digits visible, flash off, brightness 0 and a blink half
// period of 500 ticks. The configuration port writes the blink half period
// (index 0) or the stored brightness (index 1), which also loads the current
// brightness; write it only while no beat is in flight.
module clock_setting_menu_controller_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  cscm_pkg::in_t                      in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output cscm_pkg::out_t                     out_data_o,
  input  logic                               cfg_we_i,
  input  logic [cscm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [cscm_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  logic             item_valid;
  logic             res_ready;
  logic             advance;
  cscm_pkg::in_t    item;
  cscm_pkg::out_t   res;
  cscm_pkg::state_t state_q;
  cscm_pkg::state_t state_d;
  cscm_pkg::state_t state_nxt;
  logic [15:0]      half_period_q;

  // Input register.
  cscm_stage #(.T(cscm_pkg::in_t)) u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (item_valid),
    .ready_i (res_ready),
    .data_o  (item)
  );

  // The event logic: next menu state and the result beat.
  cscm_next u_next (
    .st_i          (state_q),
    .item_i        (item),
    .half_period_i (half_period_q),
    .st_o          (state_nxt),
    .res_o         (res)
  );

  // Output register.
  cscm_stage #(.T(cscm_pkg::out_t)) u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (item_valid),
    .ready_o (res_ready),
    .data_i  (res),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

  // Besides configuration writes, the menu state moves only when the event's
  // result enters the output register, so the following event sees the update.
  assign advance = item_valid && res_ready;

  always_comb begin
    state_d = state_q;
    if (advance) begin
      state_d = state_nxt;
    end
    if (cfg_we_i && (cfg_idx_i == cscm_pkg::REG_START_BRIGHT)) begin
      state_d.bright = cfg_data_i[3:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode     <= cscm_pkg::MODE_MAIN;
      state_q.position <= 2'd0;
      state_q.field    <= 1'b0;
      state_q.hour     <= 5'd0;
      state_q.minute   <= 6'd0;
      state_q.bright   <= cscm_pkg::START_BRIGHT_RST;
      state_q.visible  <= 1'b1;
      state_q.flash    <= 1'b0;
      state_q.elapsed  <= 16'd0;
      state_q.prev_pin <= 1'b0;
      half_period_q    <= cscm_pkg::HALF_PERIOD_RST;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && (cfg_idx_i == cscm_pkg::REG_HALF_PERIOD)) begin
        half_period_q <= cfg_data_i[15:0];
      end
    end
  end

  // A cleared alarm command always comes with the ringing mode.
  a_clr_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.command == cscm_pkg::CMD_CLR_ALARM)
    |-> (out_data_o.mode == cscm_pkg::MODE_RING))
    else $error("clear-alarm command outside ringing mode");

  // Flash is only reported while ringing.
  a_flash_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.flash_on |-> (out_data_o.mode == cscm_pkg::MODE_RING))
    else $error("flash reported outside ringing mode");

  // A commit or save returns to the main menu at position 0, minutes field.
  a_commit_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_data_o.command == cscm_pkg::CMD_WR_TIME) ||
                    (out_data_o.command == cscm_pkg::CMD_WR_ALARM) ||
                    (out_data_o.command == cscm_pkg::CMD_SAVE_BRT))
    |-> (out_data_o.mode == cscm_pkg::MODE_MAIN) && (out_data_o.menu_position == 2'd0) &&
        !out_data_o.edit_hours)
    else $error("commit did not return to main menu");

  // While the result is stalled no event may touch the menu state.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && !cfg_we_i |=> $stable(state_q))
    else $error("menu state changed while output stalled");

endmodule

// ----- bench/clock_setting_menu_controller_top_test.sv -----
// Testbench for the alarm clock menu controller.
module clock_setting_menu_controller_top_test;

  // The whole run stays far below this; it only catches a hung handshake.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid_i = 1'b0;
  logic                            in_ready_o;
  cscm_pkg::in_t                   in_data_i = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  cscm_pkg::out_t                  out_data_o;
  logic                            cfg_we_i = 1'b0;
  logic [cscm_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [cscm_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  clock_setting_menu_controller_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Events waiting to be offered, and the menu states the block owes us, in
  // the order the events were accepted.
  cscm_pkg::in_t  pending_events_q[$];
  cscm_pkg::out_t expected_menu_q[$];
  int unsigned queued_events = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  // Set by the posedge process when the input beat was taken, so the driver
  // knows at the following falling edge whether to move on.
  bit beat_taken = 1'b0;
  // While set, neither side inserts idle cycles.
  bit no_gaps = 1'b0;

  // Our own copy of the menu state and of the two registers. The hour and
  // minute are kept as plain integers so that wraps below zero and
  // out-of-range clock reads follow the same compare rules as the block.
  cscm_pkg::mode_e menu_mode = cscm_pkg::MODE_MAIN;
  logic [1:0]      menu_pos = 2'd0;
  logic            menu_field = 1'b0;
  int              menu_hour = 0;
  int              menu_min = 0;
  int              menu_bright = int'(cscm_pkg::START_BRIGHT_RST);
  logic            menu_visible = 1'b1;
  logic            menu_flash = 1'b0;
  logic            pin_prev = 1'b0;
  int              tick_count = 0;
  int              blink_half = int'(cscm_pkg::HALF_PERIOD_RST);

  // An encoder step. In main mode it moves the selection with wrap; in the
  // set modes it edits the selected field and restarts the blink so the
  // digits show; in brightness mode it saturates at both ends. While
  // ringing it does nothing.
  function automatic void turn_knob(bit right);
    if (menu_mode == cscm_pkg::MODE_MAIN) begin
      menu_pos = right ? menu_pos + 2'd1 : menu_pos - 2'd1;
    end else if (menu_mode == cscm_pkg::MODE_TIME || menu_mode == cscm_pkg::MODE_ALARM) begin
      tick_count = 0;
      menu_visible = 1'b1;
      if (right) begin
        if (menu_field) menu_hour++;
        else menu_min++;
        // A minute past the top carries into the hour on any increment,
        // which also covers minutes above 59 read from the clock chip.
        if (menu_min > int'(cscm_pkg::MINUTE_MAX)) begin
          menu_min = 0;
          menu_hour++;
        end
        if (menu_hour > int'(cscm_pkg::HOUR_MAX)) menu_hour = 0;
      end else begin
        if (menu_field) menu_hour--;
        else menu_min--;
        if (menu_min < 0) begin
          menu_min = int'(cscm_pkg::MINUTE_MAX);
          menu_hour--;
        end
        // Going below hour zero lands on 23:59, whichever field is edited.
        if (menu_hour < 0) begin
          menu_hour = int'(cscm_pkg::HOUR_MAX);
          menu_min = int'(cscm_pkg::MINUTE_MAX);
        end
      end
    end else if (menu_mode == cscm_pkg::MODE_BRIGHT) begin
      if (right) begin
        if (menu_bright < int'(cscm_pkg::BRIGHT_MAX)) menu_bright++;
      end else begin
        if (menu_bright > 0) menu_bright--;
      end
    end
  endfunction

  // An encoder press. A press while ringing first drops back to main at
  // position 0, and then acts as a press in main, which at position 0 stays
  // in main. The flash bit is left as it is.
  function automatic cscm_pkg::cmd_e press_knob();
    cscm_pkg::cmd_e cmd;
    cmd = cscm_pkg::CMD_NONE;
    if (menu_mode == cscm_pkg::MODE_RING) begin
      menu_mode = cscm_pkg::MODE_MAIN;
      menu_pos = 2'd0;
    end
    if (menu_mode == cscm_pkg::MODE_MAIN) begin
      menu_mode = cscm_pkg::mode_e'({1'b0, menu_pos});
    end else if (menu_mode == cscm_pkg::MODE_TIME || menu_mode == cscm_pkg::MODE_ALARM) begin
      if (!menu_field) begin
        menu_field = 1'b1;
      end else begin
        cmd = (menu_mode == cscm_pkg::MODE_TIME) ? cscm_pkg::CMD_WR_TIME :
                                                   cscm_pkg::CMD_WR_ALARM;
        menu_field = 1'b0;
        menu_mode = cscm_pkg::MODE_MAIN;
        menu_pos = 2'd0;
      end
    end else if (menu_mode == cscm_pkg::MODE_BRIGHT) begin
      cmd = cscm_pkg::CMD_SAVE_BRT;
      menu_field = 1'b0;
      menu_mode = cscm_pkg::MODE_MAIN;
      menu_pos = 2'd0;
    end
    return cmd;
  endfunction

  // Applies one event to the menu copy and returns the state the block
  // must report for it.
  function automatic cscm_pkg::out_t step_menu(cscm_pkg::in_t ev);
    cscm_pkg::out_t res;
    cscm_pkg::cmd_e cmd;
    cmd = cscm_pkg::CMD_NONE;
    case (ev.kind)
      cscm_pkg::KIND_TICK: begin
        // The counter stops at its ceiling, so a half period of 65535
        // never toggles anything.
        if (tick_count < 'hFFFF) tick_count++;
        if (tick_count > blink_half) begin
          if (menu_mode == cscm_pkg::MODE_TIME || menu_mode == cscm_pkg::MODE_ALARM) begin
            menu_visible = ~menu_visible;
            tick_count = 0;
          end else if (menu_mode == cscm_pkg::MODE_RING) begin
            menu_flash = ~menu_flash;
            tick_count = 0;
          end
        end
      end
      cscm_pkg::KIND_RIGHT: turn_knob(1'b1);
      cscm_pkg::KIND_LEFT:  turn_knob(1'b0);
      cscm_pkg::KIND_PRESS: cmd = press_knob();
      cscm_pkg::KIND_RTC: begin
        // A time read only lands while the clock face itself is shown.
        if (menu_mode == cscm_pkg::MODE_MAIN && menu_pos == 2'd0) begin
          menu_hour = int'(ev.rtc_hour);
          menu_min = int'(ev.rtc_minute);
        end
      end
      cscm_pkg::KIND_PIN: begin
        // A falling pin with the alarm flag set starts ringing from any
        // mode; the edited field is kept.
        if (!ev.pin_level && pin_prev && ev.alarm_flag) begin
          menu_mode = cscm_pkg::MODE_RING;
          cmd = cscm_pkg::CMD_CLR_ALARM;
        end
        pin_prev = ev.pin_level;
      end
      default: ;
    endcase
    res.mode           = menu_mode;
    res.menu_position  = menu_pos;
    res.edit_hours     = menu_field;
    res.hours          = menu_hour[4:0];
    res.minutes        = menu_min[5:0];
    res.level          = menu_bright[3:0];
    res.digits_visible = menu_visible;
    res.flash_on       = (menu_mode == cscm_pkg::MODE_RING) ? menu_flash : 1'b0;
    res.command        = cmd;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic check_field(string what, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Every event carries random values in the fields it does not use, and
  // now and then a clock time beyond 23:59, so all field bits get toggled.
  function automatic cscm_pkg::in_t random_event(logic [2:0] kind);
    cscm_pkg::in_t ev;
    ev.kind       = kind;
    ev.rtc_hour   = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(24, 31))
                                                : 5'($urandom_range(0, 23));
    ev.rtc_minute = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(60, 63))
                                                : 6'($urandom_range(0, 59));
    ev.pin_level  = 1'($urandom_range(0, 1));
    ev.alarm_flag = 1'($urandom_range(0, 1));
    return ev;
  endfunction

  function automatic void queue_event(cscm_pkg::in_t ev);
    pending_events_q.push_back(ev);
    queued_events++;
  endfunction

  function automatic void push_kind(logic [2:0] kind);
    queue_event(random_event(kind));
  endfunction

  function automatic void push_time(logic [4:0] hour, logic [5:0] minute);
    cscm_pkg::in_t ev;
    ev = random_event(cscm_pkg::KIND_RTC);
    ev.rtc_hour = hour;
    ev.rtc_minute = minute;
    queue_event(ev);
  endfunction

  function automatic void push_pin(logic level, logic flag);
    cscm_pkg::in_t ev;
    ev = random_event(cscm_pkg::KIND_PIN);
    ev.pin_level = level;
    ev.alarm_flag = flag;
    queue_event(ev);
  endfunction

  // Pin high, then low with the alarm flag: the block starts ringing.
  function automatic void push_alarm();
    push_pin(1'b1, 1'($urandom_range(0, 1)));
    push_pin(1'b0, 1'b1);
  endfunction

  // One pass through the menu as a user would make it: maybe read the
  // time, pick an entry, press, edit, press, edit, press. The entry picked
  // is random, so sessions end up in every mode. Sometimes the alarm goes
  // off in the middle and gets pressed away.
  function automatic void push_session();
    if ($urandom_range(0, 2) == 0) push_kind(cscm_pkg::KIND_RTC);
    repeat ($urandom_range(0, 4)) begin
      push_kind($urandom_range(0, 1) ? cscm_pkg::KIND_RIGHT : cscm_pkg::KIND_LEFT);
    end
    push_kind(cscm_pkg::KIND_PRESS);
    repeat (2) begin
      repeat ($urandom_range(0, 12)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: push_kind(cscm_pkg::KIND_RIGHT);
          4, 5, 6, 7: push_kind(cscm_pkg::KIND_LEFT);
          default:    push_kind(cscm_pkg::KIND_TICK);
        endcase
      end
      if ($urandom_range(0, 9) == 0) begin
        push_alarm();
        repeat ($urandom_range(0, 6)) push_kind(cscm_pkg::KIND_TICK);
      end
      push_kind(cscm_pkg::KIND_PRESS);
    end
  endfunction

  // Mostly whole sessions; the rest is noise of any kind, the unused kinds
  // and stray pin changes among it.
  function automatic void push_random(int unsigned count);
    int unsigned goal;
    goal = queued_events + count;
    while (queued_events < goal) begin
      if ($urandom_range(0, 9) < 7) push_session();
      else push_kind(3'($urandom_range(0, 7)));
    end
  endfunction

  // Writes both registers on back-to-back cycles, then mirrors them into
  // the menu copy. The stored brightness also loads the live brightness.
  // Only called while nothing is in flight. The upper bits of the
  // brightness word are random since the block must ignore them.
  task automatic configure(logic [15:0] half, logic [3:0] bright);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= cscm_pkg::REG_HALF_PERIOD;
    cfg_data_i <= half;
    @(negedge clk_i);
    cfg_idx_i  <= cscm_pkg::REG_START_BRIGHT;
    cfg_data_i <= {12'($urandom()), bright};
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    blink_half = int'(half);
    menu_bright = int'(bright);
  endtask

  // Holds the sender off until every queued event went in and every
  // expected beat came out, then lets the two pipeline stages settle.
  task automatic wait_drained();
    while (pending_events_q.size() != 0 || in_valid_i || expected_menu_q.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Input side. Acceptance is seen at the rising edge, where the expected
  // menu state is worked out from the beat that went in.
  always @(posedge clk_i) begin
    beat_taken = rst_ni && in_valid_i && in_ready_o;
    if (beat_taken) expected_menu_q.push_back(step_menu(in_data_i));
  end

  // The driver moves at the falling edge. A beat that is still waiting is
  // held as it is; otherwise the next event goes out, or the channel idles
  // in about a third of the cycles.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || beat_taken) begin
      if (pending_events_q.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 33)) begin
        in_data_i  <= pending_events_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output side: the receiver stalls in about a third of the cycles.
  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && (no_gaps || $urandom_range(0, 99) >= 33);
  end

  // Every result beat is checked field by field against the oldest
  // expectation.
  always @(posedge clk_i) begin : check_results
    cscm_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_menu_q.size() == 0) begin
        report_mismatch("result beat with none expected", 16'd1, 16'd0);
      end else begin
        want = expected_menu_q.pop_front();
        check_field("mode", 16'(out_data_o.mode), 16'(want.mode));
        check_field("menu_position", 16'(out_data_o.menu_position),
                    16'(want.menu_position));
        check_field("edit_hours", 16'(out_data_o.edit_hours), 16'(want.edit_hours));
        check_field("hours", 16'(out_data_o.hours), 16'(want.hours));
        check_field("minutes", 16'(out_data_o.minutes), 16'(want.minutes));
        check_field("level", 16'(out_data_o.level), 16'(want.level));
        check_field("digits_visible", 16'(out_data_o.digits_visible),
                    16'(want.digits_visible));
        check_field("flash_on", 16'(out_data_o.flash_on), 16'(want.flash_on));
        check_field("command", 16'(out_data_o.command), 16'(want.command));
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** clock_setting_menu_controller_top: FAILED **");
    $finish;
  end

  initial begin : stimulus
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed walk with a blink half period of 1 and full brightness.
    configure(16'd1, 4'd15);
    push_time(5'd23, 6'd59);        // lands, main at the clock face
    push_kind(cscm_pkg::KIND_RIGHT); // select set time
    push_kind(cscm_pkg::KIND_PRESS);
    push_kind(cscm_pkg::KIND_RIGHT); // 23:59 rolls over to 00:00
    push_kind(cscm_pkg::KIND_LEFT);  // and back under zero to 23:59
    push_kind(cscm_pkg::KIND_PRESS); // now editing hours
    push_kind(cscm_pkg::KIND_RIGHT); // hour 23 wraps to 0
    push_kind(cscm_pkg::KIND_LEFT);  // hour below zero gives 23:59
    push_kind(cscm_pkg::KIND_TICK);
    push_kind(cscm_pkg::KIND_TICK);  // second tick blanks the digits
    push_kind(cscm_pkg::KIND_PRESS); // commit the time
    push_kind(cscm_pkg::KIND_LEFT);  // selection wraps down to brightness
    push_kind(cscm_pkg::KIND_PRESS);
    push_kind(cscm_pkg::KIND_RIGHT); // already at the top, stays at 15
    push_kind(cscm_pkg::KIND_LEFT);
    push_kind(cscm_pkg::KIND_PRESS); // save brightness
    push_kind(cscm_pkg::KIND_LEFT);
    push_kind(cscm_pkg::KIND_LEFT);  // select set alarm
    push_kind(cscm_pkg::KIND_PRESS);
    push_pin(1'b1, 1'b0);
    push_pin(1'b0, 1'b1);           // alarm edge while editing: ringing
    push_kind(cscm_pkg::KIND_RIGHT); // turns are ignored while ringing
    push_kind(cscm_pkg::KIND_TICK);
    push_kind(cscm_pkg::KIND_TICK);  // flash toggles
    push_kind(cscm_pkg::KIND_PRESS); // back to main at the clock face
    push_time(5'd31, 6'd63);        // a time read out of range
    push_kind(3'd6);
    push_kind(3'd7);
    wait_drained();

    // Random phases over a spread of register settings, both brightness ends
    // and the largest half period among them. Brightness 0 lets the lower saturation show up.
    configure(16'd1, 4'd0);
    push_random(500);
    wait_drained();
    configure(16'hFFFF, 4'd15);
    push_random(400);
    wait_drained();
    configure(16'($urandom_range(2, 40)), 4'($urandom_range(0, 15)));
    push_random(500);
    wait_drained();
    configure(cscm_pkg::HALF_PERIOD_RST, 4'd7);
    push_random(400);
    wait_drained();

    // A long stretch with no idle cycles on either side.
    no_gaps = 1'b1;
    configure(16'($urandom_range(1, 8)), 4'($urandom_range(0, 15)));
    push_random(200);
    wait_drained();
    no_gaps = 1'b0;

    if (mismatch_count == 0) begin
      $display("** clock_setting_menu_controller_top: PASSED **");
    end else begin
      $display("** clock_setting_menu_controller_top: FAILED **");
    end
    $finish;
  end

endmodule
